@@ design/seam_feather_blend_top_defines.svh @@
// ---------------------------------------------------------------------------
// Seam feather blend assertion macros
// Concurrent assertion helpers shared by the blend block; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef SEAM_FEATHER_BLEND_TOP_DEFINES_SVH
`define SEAM_FEATHER_BLEND_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define SFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/sfb_pkg.sv @@
// ---------------------------------------------------------------------------
// Seam feather blend package
// Shared widths, register indexes and structs of the blend block.
// ---------------------------------------------------------------------------
package sfb_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_LANES = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_INV   = 2'd2
  } cfg_reg_t;

  // Per-word decisions made ahead of the lanes.
  typedef struct packed {
    logic in_band;
    logic left_black;
    logic warp_black;
  } sfb_flags_t;

  typedef struct packed {
    logic             write_enable;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } sfb_pix_t;

endpackage

@@ design/sfb_if.sv @@
// ---------------------------------------------------------------------------
// Seam feather blend channels
// Valid/ready interfaces for the pixel pair input and the blended output.
// ---------------------------------------------------------------------------
interface sfb_in_if #(
  parameter int COL_W = 12
);
  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        column;
  logic [sfb_pkg::PIX_W-1:0] left_red;
  logic [sfb_pkg::PIX_W-1:0] left_green;
  logic [sfb_pkg::PIX_W-1:0] left_blue;
  logic [sfb_pkg::PIX_W-1:0] warp_red;
  logic [sfb_pkg::PIX_W-1:0] warp_green;
  logic [sfb_pkg::PIX_W-1:0] warp_blue;

  modport source (
    output valid, column, left_red, left_green, left_blue,
           warp_red, warp_green, warp_blue,
    input  ready
  );
  modport sink (
    input  valid, column, left_red, left_green, left_blue,
           warp_red, warp_green, warp_blue,
    output ready
  );
endinterface

interface sfb_out_if;
  logic                      valid;
  logic                      ready;
  logic                      write_enable;
  logic [sfb_pkg::PIX_W-1:0] out_red;
  logic [sfb_pkg::PIX_W-1:0] out_green;
  logic [sfb_pkg::PIX_W-1:0] out_blue;

  modport source (
    output valid, write_enable, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, write_enable, out_red, out_green, out_blue,
    output ready
  );
endinterface

@@ design/seam_feather_blend_top.sv @@
// ---------------------------------------------------------------------------
// Seam feather blend top level
// Linear feather blend of a left and a warped right pixel across the seam.
// ---------------------------------------------------------------------------
// Usage: pixel pairs arrive on in_pix, one word per pixel with its column;
// one result word per pixel leaves on out_pix. write_enable marks columns in
// [overlap_start, overlap_end); other columns give an all-zero pixel.
// The cfg port writes overlap_start, overlap_end and inverse_width
// (Q1.FRAC_BITS reciprocal of the band width) while no pixel is in flight.
// Throughput is one word per cycle while the skid register is empty; a word
// passes from acceptance to out_pix.valid through four register stages:
// band compare, weight multiply, channel products in three side-by-side
// lanes, then the merged result in the output register.
// A stalled receiver fills one skid register; in_pix.ready drops only while
// it is full and the whole pipeline holds. Reset empties the pipeline, keeps
// in_pix.ready low and loads start 0, end MAX_WIDTH and inverse width 16.
// ---------------------------------------------------------------------------
`include "seam_feather_blend_top_defines.svh"

module seam_feather_blend_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfb_in_if.sink                          in_pix,
  sfb_out_if.source                       out_pix,
  input  logic                            cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [((($clog2(MAX_WIDTH) + 1) > (FRAC_BITS + 1)) ?
                 ($clog2(MAX_WIDTH) + 1) : (FRAC_BITS + 1))-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int END_W = COL_W + 1;
  localparam int A_W   = FRAC_BITS + 1;
  localparam int MUL_W = END_W + A_W;
  localparam int PW    = sfb_pkg::PIX_W;
  localparam int NL    = sfb_pkg::NUM_LANES;
  localparam logic [A_W-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [END_W-1:0] END_MAX = END_W'(MAX_WIDTH);

  // Configuration registers.
  logic [COL_W-1:0] start_r;
  logic [END_W-1:0] end_r;
  logic [A_W-1:0]   inv_r;
  logic [END_W-1:0] end_wr;

  assign end_wr = cfg_data[END_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= END_MAX;
      inv_r   <= A_W'(16);
    end else if (cfg_we) begin
      unique case (sfb_pkg::cfg_reg_t'(cfg_index))
        sfb_pkg::REG_START: start_r <= cfg_data[COL_W-1:0];
        sfb_pkg::REG_END:   end_r   <= (end_wr > END_MAX) ? END_MAX : end_wr;
        sfb_pkg::REG_INV:   inv_r   <= cfg_data[A_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the skid register is free.
  logic en;
  logic skid_valid_r;
  logic out_valid_r;

  assign en           = !skid_valid_r;
  assign in_pix.ready = en && rst_n;

  logic [PW-1:0] in_left [NL];
  logic [PW-1:0] in_warp [NL];

  assign in_left[0] = in_pix.left_red;
  assign in_left[1] = in_pix.left_green;
  assign in_left[2] = in_pix.left_blue;
  assign in_warp[0] = in_pix.warp_red;
  assign in_warp[1] = in_pix.warp_green;
  assign in_warp[2] = in_pix.warp_blue;

  // Stage 1: band compare and distance to the band end.
  sfb_pkg::sfb_flags_t flags_nxt;
  logic [END_W-1:0]    diff_nxt;

  assign flags_nxt.in_band    = (in_pix.column >= start_r) &&
                                (END_W'(in_pix.column) < end_r);
  assign flags_nxt.left_black = (in_pix.left_red == '0) && (in_pix.left_green == '0) &&
                                (in_pix.left_blue == '0);
  assign flags_nxt.warp_black = (in_pix.warp_red == '0) && (in_pix.warp_green == '0) &&
                                (in_pix.warp_blue == '0);
  assign diff_nxt             = end_r - END_W'(in_pix.column);

  logic                s1_valid_r;
  sfb_pkg::sfb_flags_t s1_flags_r;
  logic [END_W-1:0]    s1_diff_r;
  logic [PW-1:0]       s1_left_r [NL];
  logic [PW-1:0]       s1_warp_r [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags_r <= flags_nxt;
      s1_diff_r  <= diff_nxt;
      s1_left_r  <= in_left;
      s1_warp_r  <= in_warp;
    end
  end

  // Stage 2: left weight, saturated to exactly one.
  logic [MUL_W-1:0] wprod;
  logic [A_W-1:0]   alpha_nxt;

  assign wprod     = MUL_W'(s1_diff_r) * MUL_W'(inv_r);
  assign alpha_nxt = (wprod > MUL_W'(ONE)) ? ONE : wprod[A_W-1:0];

  logic                s2_valid_r;
  sfb_pkg::sfb_flags_t s2_flags_r;
  logic [A_W-1:0]      s2_alpha_r;
  logic [PW-1:0]       s2_left_r [NL];
  logic [PW-1:0]       s2_warp_r [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_flags_r <= s1_flags_r;
      s2_alpha_r <= alpha_nxt;
      s2_left_r  <= s1_left_r;
      s2_warp_r  <= s1_warp_r;
    end
  end

  // Stage 3: one lane per color channel.
  logic                s3_valid_r;
  sfb_pkg::sfb_flags_t s3_flags_r;
  logic [PW-1:0]       lane_mix  [NL];
  logic [PW-1:0]       lane_left [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_flags_r <= s2_flags_r;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    sfb_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (en),
      .left   (s2_left_r[g]),
      .warp   (s2_warp_r[g]),
      .alpha  (s2_alpha_r),
      .mix    (lane_mix[g]),
      .left_q (lane_left[g])
    );
  end

  sfb_pkg::sfb_pix_t merged;

  sfb_merge u_merge (
    .flags  (s3_flags_r),
    .mix    (lane_mix),
    .left   (lane_left),
    .result (merged)
  );

  // Output register with one skid word behind it.
  sfb_pkg::sfb_pix_t out_r;
  sfb_pkg::sfb_pix_t skid_r;
  logic              push;
  logic              pop;

  assign push = en && s3_valid_r;
  assign pop  = out_valid_r && out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_r && !out_pix.ready) begin
          skid_r       <= merged;
          skid_valid_r <= 1'b1;
        end else begin
          out_r       <= merged;
          out_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_pix.valid        = out_valid_r;
  assign out_pix.write_enable = out_r.write_enable;
  assign out_pix.out_red      = out_r.red;
  assign out_pix.out_green    = out_r.green;
  assign out_pix.out_blue     = out_r.blue;

  `SFB_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid word held without an output word")
  `SFB_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && pop, out_valid_r && !skid_valid_r, "skid word lost on drain")
  `SFB_ASSERT_IMPLY(a_off_band_zero, clk, rst_n, out_valid_r && !out_r.write_enable, (out_r.red == '0) && (out_r.green == '0) && (out_r.blue == '0), "pixel outside the band is not zero")
  `SFB_ASSERT_IMPLY(a_alpha_bounded, clk, rst_n, s2_valid_r, s2_alpha_r <= ONE, "left weight above one")

endmodule

@@ design/sfb_lane.sv @@
// ---------------------------------------------------------------------------
// Seam feather blend channel lane
// Weights one color channel of the left and warped pixels by alpha.
// ---------------------------------------------------------------------------
module sfb_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sfb_pkg::PIX_W-1:0]   left,
  input  logic [sfb_pkg::PIX_W-1:0]   warp,
  input  logic [FRAC_BITS:0]          alpha,
  output logic [sfb_pkg::PIX_W-1:0]   mix,
  output logic [sfb_pkg::PIX_W-1:0]   left_q
);

  localparam int A_W    = FRAC_BITS + 1;
  localparam int PROD_W = sfb_pkg::PIX_W + A_W;
  localparam logic [A_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [A_W-1:0]            beta;
  logic [PROD_W-1:0]         prod_l_r;
  logic [PROD_W-1:0]         prod_w_r;
  logic [PROD_W-1:0]         sum;
  logic [sfb_pkg::PIX_W-1:0] left_r;

  assign beta = ONE - alpha;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_l_r <= PROD_W'(left) * PROD_W'(alpha);
      prod_w_r <= PROD_W'(warp) * PROD_W'(beta);
      left_r   <= left;
    end
  end

  // The weights add up to one, so the sum stays below 256 in the integer part.
  assign sum    = prod_l_r + prod_w_r;
  assign mix    = sum[FRAC_BITS +: sfb_pkg::PIX_W];
  assign left_q = left_r;

endmodule

@@ design/sfb_merge.sv @@
// ---------------------------------------------------------------------------
// Seam feather blend merge
// Combines the lane results with the band and black-pixel decisions.
// ---------------------------------------------------------------------------
module sfb_merge (
  input  sfb_pkg::sfb_flags_t          flags,
  input  logic [sfb_pkg::PIX_W-1:0]    mix    [sfb_pkg::NUM_LANES],
  input  logic [sfb_pkg::PIX_W-1:0]    left   [sfb_pkg::NUM_LANES],
  output sfb_pkg::sfb_pix_t            result
);

  always_comb begin
    result = '0;
    priority if (!flags.in_band) begin
      result = '0;
    end else if (flags.left_black) begin
      result.write_enable = 1'b1;
    end else if (flags.warp_black) begin
      result.write_enable = 1'b1;
      result.red          = left[0];
      result.green        = left[1];
      result.blue         = left[2];
    end else begin
      result.write_enable = 1'b1;
      result.red          = mix[0];
      result.green        = mix[1];
      result.blue         = mix[2];
    end
  end

endmodule
